/* hw/rtl/prefixed_integer_text_parser_macros.svh */
// Assertion macros for the prefixed integer text parser.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef PREFIXED_INTEGER_TEXT_PARSER_MACROS_SVH
`define PREFIXED_INTEGER_TEXT_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PITP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PITP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pitp_pkg.sv */
// Package for the prefixed integer text parser: types, character codes and the digit classifier.
// It has no dependencies; the top level imports it.
package pitp_pkg;

	localparam int VALUE_WIDTH_DEFAULT = 32;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPPER = 8'h41;
	localparam logic [7:0] CH_LOWER = 8'h61;
	localparam logic [7:0] CH_LAST  = 8'h66;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_X     = 8'h78;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_BIN = 2'd1,
		RADIX_OCT = 2'd2,
		RADIX_HEX = 2'd3
	} radix_t;

	typedef enum logic [3:0] {
		ST_EMPTY  = 4'b0001,
		ST_SIGN   = 4'b0010,
		ST_HELD   = 4'b0100,
		ST_DIGITS = 4'b1000
	} state_t;

	typedef struct packed {
		logic       space;
		logic       bad;
		logic [3:0] value;
	} digit_t;

	function automatic digit_t classify(input logic [7:0] c, input radix_t radix);
		logic [5:0] d;
		logic [5:0] lim;
		digit_t     res;
		res.space = (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF);
		if (c < CH_UPPER) begin
			d = 6'(c - CH_ZERO);
		end else if (c < CH_LOWER) begin
			d = 6'(c - 8'h37);
		end else begin
			d = 6'(c - 8'h57);
		end
		case (radix)
			RADIX_BIN: lim = 6'd2;
			RADIX_OCT: lim = 6'd8;
			RADIX_HEX: lim = 6'd16;
			default:   lim = 6'd10;
		endcase
		res.bad   = !res.space && ((c < CH_ZERO) || (c > CH_LAST) || (d >= lim));
		res.value = d[3:0];
		return res;
	endfunction

endpackage

/* hw/rtl/prefixed_integer_text_parser.sv */
// Parses a signed integer with optional radix prefix from a stream of character words.
// An accepted end-of-text word sets the out_valid register; one word per cycle unless stalled.
// The input stage stalls only when it holds an end-of-text word and the result register is full
// and stalled. Reset (arst_n low) clears all parser state and both valid flags asynchronously.
// Depends on pitp_pkg and prefixed_integer_text_parser_macros.svh.
`include "prefixed_integer_text_parser_macros.svh"

module prefixed_integer_text_parser
	import pitp_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    character,
	input  logic                          end_of_text,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [VALUE_WIDTH-1:0] parsed_value,
	output logic                          ok
);

	logic                   valid_s1;
	logic [7:0]             char_s1;
	logic                   eot_s1;
	logic                   adv;

	state_t                 state_q, state_n;
	logic                   neg_q, neg_n;
	logic [7:0]             held_q, held_n;
	radix_t                 radix_q, radix_n;
	logic [VALUE_WIDTH-1:0] acc_q, acc_n;
	logic                   failed_q, failed_n;

	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic                   ok_q;
	logic [VALUE_WIDTH-1:0] value_n;
	logic                   ok_n;

	digit_t                 held_dig;
	digit_t                 cur_dig;
	digit_t                 stream_dig;
	logic [7:0]             held_ten;
	logic [VALUE_WIDTH-1:0] fin_acc;
	logic                   fin_fail;
	logic [VALUE_WIDTH-1:0] scaled;
	logic [VALUE_WIDTH-1:0] stream_val;

	assign adv      = valid_s1 && !(eot_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= character;
			eot_s1  <= end_of_text;
		end
	end

	assign held_dig   = classify(held_q, RADIX_DEC);
	assign cur_dig    = classify(char_s1, RADIX_DEC);
	assign stream_dig = classify(char_s1, radix_q);
	assign held_ten   = held_dig.space ? 8'd0
		: ({1'b0, held_dig.value, 3'b000} + {3'b000, held_dig.value, 1'b0});
	assign stream_val = {{(VALUE_WIDTH-4){1'b0}}, stream_dig.value};

	always_comb begin
		unique case (radix_q)
			RADIX_BIN: scaled = acc_q << 1;
			RADIX_OCT: scaled = acc_q << 3;
			RADIX_HEX: scaled = acc_q << 4;
			default:   scaled = (acc_q << 3) + (acc_q << 1);
		endcase
	end

	always_comb begin
		if (state_q == ST_HELD) begin
			fin_acc  = held_dig.space ? '0 : {{(VALUE_WIDTH-4){1'b0}}, held_dig.value};
			fin_fail = held_dig.bad;
		end else begin
			fin_acc  = acc_q;
			fin_fail = failed_q;
		end
		ok_n    = (state_q != ST_EMPTY) && !fin_fail;
		value_n = ok_n ? (neg_q ? ('0 - fin_acc) : fin_acc) : '0;
	end

	always_comb begin
		state_n  = state_q;
		neg_n    = neg_q;
		held_n   = held_q;
		radix_n  = radix_q;
		acc_n    = acc_q;
		failed_n = failed_q;
		if (eot_s1) begin
			state_n  = ST_EMPTY;
			neg_n    = 1'b0;
			held_n   = '0;
			radix_n  = RADIX_DEC;
			acc_n    = '0;
			failed_n = 1'b0;
		end else begin
			unique case (state_q)
				ST_EMPTY: begin
					if (char_s1 == CH_MINUS) begin
						neg_n   = 1'b1;
						state_n = ST_SIGN;
					end else begin
						held_n  = char_s1;
						state_n = ST_HELD;
					end
				end
				ST_SIGN: begin
					held_n  = char_s1;
					state_n = ST_HELD;
				end
				ST_HELD: begin
					state_n = ST_DIGITS;
					if (char_s1 == CH_B || char_s1 == CH_O || char_s1 == CH_X) begin
						radix_n  = (char_s1 == CH_B) ? RADIX_BIN
							: (char_s1 == CH_O) ? RADIX_OCT : RADIX_HEX;
						failed_n = (held_q != CH_ZERO);
					end else if (held_dig.bad || cur_dig.bad) begin
						failed_n = 1'b1;
					end else if (cur_dig.space) begin
						acc_n = held_dig.space ? '0 : {{(VALUE_WIDTH-4){1'b0}}, held_dig.value};
					end else if (held_dig.space) begin
						acc_n = {{(VALUE_WIDTH-4){1'b0}}, cur_dig.value};
					end else begin
						acc_n = VALUE_WIDTH'(held_ten) + {{(VALUE_WIDTH-4){1'b0}}, cur_dig.value};
					end
				end
				ST_DIGITS: begin
					if (!failed_q && !stream_dig.space) begin
						if (stream_dig.bad) begin
							failed_n = 1'b1;
						end else begin
							acc_n = scaled + stream_val;
						end
					end
				end
				default: begin
					state_n = ST_EMPTY;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_EMPTY;
			neg_q    <= 1'b0;
			held_q   <= '0;
			radix_q  <= RADIX_DEC;
			acc_q    <= '0;
			failed_q <= 1'b0;
		end else if (adv) begin
			state_q  <= state_n;
			neg_q    <= neg_n;
			held_q   <= held_n;
			radix_q  <= radix_n;
			acc_q    <= acc_n;
			failed_q <= failed_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && eot_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && eot_s1) begin
			value_q <= value_n;
			ok_q    <= ok_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign parsed_value = value_q;
	assign ok           = ok_q;

	`PITP_ASSERT_NOW(a_fail_is_zero, out_valid && !ok, parsed_value == '0,
		"A failed parse must report a zero value.")
	`PITP_ASSERT_NOW(a_stall_cause, in_stall, valid_s1 && eot_s1 && out_valid_q && out_stall,
		"The input stalled without a blocked end-of-text word.")
	`PITP_ASSERT_NEXT(a_end_clears, adv && eot_s1, state_q == ST_EMPTY && !failed_q && acc_q == '0,
		"Parser state did not return to empty after an end-of-text word.")

endmodule

/* test/prefixed_integer_text_parser_tb.sv */
// Self-checking testbench for prefixed_integer_text_parser: text words go in through a queue,
// and an internal parser model predicts each value and ok flag on every end-of-text word.
// Depends on pitp_pkg and the RTL of the block.
`timescale 1ns / 100ps

module prefixed_integer_text_parser_tb;
	import pitp_pkg::*;

	localparam int VW = VALUE_WIDTH_DEFAULT;

	typedef struct {
		logic [7:0] ch;
		logic       eot;
	} text_word_t;

	typedef struct {
		logic signed [VW-1:0] value;
		logic                 ok;
	} number_t;

	typedef enum logic [1:0] {
		SEEN_NOTHING,
		SEEN_SIGN,
		SEEN_HELD,
		SEEN_STREAMING
	} progress_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           character = 8'd0;
	logic                 end_of_text = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [VW-1:0] parsed_value;
	logic                 ok;

	text_word_t pending_words[$];
	number_t    expected_numbers[$];
	text_word_t next_word;
	number_t    oldest_number;
	int         send_idle_pct = 22;
	int         stall_pct = 70;
	int         words_queued = 0;
	int         hold_requests = 0;
	int         holds_served = 0;
	int         hold_left = 0;
	int         errors = 0;

	progress_t   seen = SEEN_NOTHING;
	logic        negative = 1'b0;
	logic [7:0]  held = 8'd0;
	radix_t      radix = RADIX_DEC;
	logic [VW-1:0] total = '0;
	logic        failed = 1'b0;

	prefixed_integer_text_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.character(character),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.parsed_value(parsed_value),
		.ok(ok)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("prefixed_integer_text_parser_tb: errors");
		$finish;
	end

	function automatic void accumulate_digit(logic [7:0] c);
		logic [5:0]    d;
		logic [VW-1:0] base;
		if (failed || c == CH_SPACE || c == CH_CR || c == CH_LF)
			return;
		if (c < CH_ZERO || c > CH_LAST) begin
			failed = 1'b1;
			return;
		end
		if (c < CH_UPPER)
			d = 6'(c - CH_ZERO);
		else if (c < CH_LOWER)
			d = 6'(c - CH_UPPER) + 6'd10;
		else
			d = 6'(c - CH_LOWER) + 6'd10;
		case (radix)
			RADIX_BIN: base = 2;
			RADIX_OCT: base = 8;
			RADIX_HEX: base = 16;
			default:   base = 10;
		endcase
		if (VW'(d) >= base)
			failed = 1'b1;
		else
			total = total * base + VW'(d);
	endfunction

	function automatic void parse_word(logic [7:0] c, logic eot);
		number_t       n;
		logic [VW-1:0] v;
		if (eot) begin
			if (seen == SEEN_HELD)
				accumulate_digit(held);
			n.ok = (seen != SEEN_NOTHING) && !failed;
			v = negative ? -total : total;
			n.value = n.ok ? v : '0;
			expected_numbers.push_back(n);
			seen = SEEN_NOTHING;
			negative = 1'b0;
			held = 8'd0;
			radix = RADIX_DEC;
			total = '0;
			failed = 1'b0;
			return;
		end
		case (seen)
			SEEN_NOTHING: begin
				if (c == CH_MINUS) begin
					negative = 1'b1;
					seen = SEEN_SIGN;
				end else begin
					held = c;
					seen = SEEN_HELD;
				end
			end
			SEEN_SIGN: begin
				held = c;
				seen = SEEN_HELD;
			end
			SEEN_HELD: begin
				if (c == CH_B || c == CH_O || c == CH_X) begin
					radix = (c == CH_B) ? RADIX_BIN : (c == CH_O) ? RADIX_OCT : RADIX_HEX;
					if (held != CH_ZERO)
						failed = 1'b1;
				end else begin
					accumulate_digit(held);
					accumulate_digit(c);
				end
				seen = SEEN_STREAMING;
			end
			default: accumulate_digit(c);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			character <= 8'd0;
			end_of_text <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				parse_word(character, end_of_text);
			if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_word = pending_words.pop_front();
				in_valid <= 1'b1;
				character <= next_word.ch;
				end_of_text <= next_word.eot;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_numbers.size() == 0) begin
					$error("result word with nothing expected: parsed_value %0d ok %0b",
						parsed_value, ok);
					errors++;
				end else begin
					oldest_number = expected_numbers.pop_front();
					if (parsed_value !== oldest_number.value) begin
						$error("parsed_value: expected %0d, got %0d", oldest_number.value,
							parsed_value);
						errors++;
					end
					if (ok !== oldest_number.ok) begin
						$error("ok: expected %0b, got %0b", oldest_number.ok, ok);
						errors++;
					end
				end
			end
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = 80;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	task automatic push_word(logic [7:0] c, logic eot);
		text_word_t w;
		w.ch = c;
		w.eot = eot;
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_word(s[i], 1'b0);
		push_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_random_text();
		int         kind;
		int         ndig;
		int         d;
		int         base;
		radix_t     rx;
		logic [7:0] ws;
		kind = $urandom_range(0, 99);
		if (kind < 80) begin
			if ($urandom_range(0, 2) == 0)
				push_word(CH_MINUS, 1'b0);
			rx = radix_t'($urandom_range(0, 3));
			case (rx)
				RADIX_BIN: base = 2;
				RADIX_OCT: base = 8;
				RADIX_HEX: base = 16;
				default:   base = 10;
			endcase
			if (rx != RADIX_DEC) begin
				push_word(CH_ZERO, 1'b0);
				push_word(rx == RADIX_BIN ? CH_B : rx == RADIX_OCT ? CH_O : CH_X, 1'b0);
			end
			ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
			repeat (ndig) begin
				if ($urandom_range(0, 9) == 0) begin
					case ($urandom_range(0, 2))
						0:       ws = CH_SPACE;
						1:       ws = CH_CR;
						default: ws = CH_LF;
					endcase
					push_word(ws, 1'b0);
				end
				d = $urandom_range(0, base - 1);
				if (d < 10)
					push_word(8'(CH_ZERO + d), 1'b0);
				else
					push_word(8'(($urandom_range(0, 1) ? CH_LOWER : CH_UPPER) + d - 10), 1'b0);
			end
		end else begin
			repeat ($urandom_range(0, 6))
				push_word($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(8'h2D, 8'h7A)), 1'b0);
		end
		push_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic drain_words();
		while (pending_words.size() != 0 || in_valid)
			@(negedge clk);
	endtask

	initial begin
		send_text("");
		send_text("-");
		send_text("5");
		send_text("0xFf");
		send_text("-0b1");
		send_text("7o");
		send_text(" \r\n");
		push_word(8'hFF, 1'b0);
		push_word(8'h00, 1'b1);
		while (words_queued < 130)
			send_random_text();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		drain_words();

		send_idle_pct = 70;
		stall_pct = 22;
		while (words_queued < 260)
			send_random_text();
		drain_words();

		while (expected_numbers.size() != 0)
			@(negedge clk);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_requests++;
		repeat (25)
			send_text($urandom_range(0, 1) ? "9" : "-");
		drain_words();

		while (words_queued < 420)
			send_random_text();
		drain_words();

		while (expected_numbers.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		errors += expected_numbers.size();
		if (errors == 0)
			$display("prefixed_integer_text_parser_tb: clean");
		else
			$display("prefixed_integer_text_parser_tb: errors");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/pitp_pkg.sv
hw/rtl/prefixed_integer_text_parser.sv
test/prefixed_integer_text_parser_tb.sv
